// File: rtl/matrix_multiply_accumulate_macros.svh
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate assertion macros
// Shared concurrent assertion wrappers. Define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH
`define MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MMA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("mma: assertion failed");
`define MMA_NEVER(lbl, clk, rstn, cond) `MMA_ASSERT(lbl, clk, rstn, !(cond))
`else
`define MMA_ASSERT(lbl, clk, rstn, prop)
`define MMA_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// File: rtl/mma_pkg.sv
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate package
// Field types, request codes and status types shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package mma_pkg;

  localparam int DimDefault  = 8;
  localparam int SizeReset   = 8;

  typedef logic [2:0]  mode_t;
  typedef logic [2:0]  idx_t;
  typedef logic [31:0] word_t;
  typedef logic [3:0]  size_t;

  localparam mode_t ModeWrA  = 3'd0;
  localparam mode_t ModeWrB  = 3'd1;
  localparam mode_t ModeWrC  = 3'd2;
  localparam mode_t ModeAcc  = 3'd3;
  localparam mode_t ModeRdC  = 3'd4;

  typedef struct packed {
    logic busy;
    logic rd_en;
    logic c_we;
  } seq_stat_t;

endpackage

`default_nettype wire

// File: rtl/mma_in_if.sv
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate request channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface mma_in_if;
  import mma_pkg::*;

  logic  valid;
  logic  ready;
  mode_t mode;
  idx_t  row;
  idx_t  col;
  word_t value;

  modport source (output valid, output mode, output row, output col, output value,
                  input ready);
  modport sink   (input valid, input mode, input row, input col, input value,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/mma_out_if.sv
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate result channel
// Valid/ready channel carrying one read-back element of C.
// ----------------------------------------------------------------------------
`default_nettype none

interface mma_out_if;
  import mma_pkg::*;

  logic  valid;
  logic  ready;
  word_t element;
  idx_t  out_row;
  idx_t  out_col;

  modport source (output valid, output element, output out_row, output out_col,
                  input ready);
  modport sink   (input valid, input element, input out_row, input out_col,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/mma_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mma_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/mma_seq.sv
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate sequencer
// Walks the output elements, streams A and B reads into a registered
// multiplier and an accumulator, and writes each finished sum back to C.
// ----------------------------------------------------------------------------
`default_nettype none

module mma_seq #(
  parameter int Dim = mma_pkg::DimDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [$clog2(Dim+1)-1:0]      size_i,
  input  wire mma_pkg::word_t                a_rdata_i,
  input  wire mma_pkg::word_t                b_rdata_i,
  input  wire mma_pkg::word_t                c_rdata_i,
  output logic      [$clog2(Dim*Dim)-1:0]    a_raddr_o,
  output logic      [$clog2(Dim*Dim)-1:0]    b_raddr_o,
  output logic      [$clog2(Dim*Dim)-1:0]    c_raddr_o,
  output logic      [$clog2(Dim*Dim)-1:0]    c_waddr_o,
  output mma_pkg::word_t                     c_wdata_o,
  output mma_pkg::seq_stat_t                 stat_o
);
  import mma_pkg::*;

`include "matrix_multiply_accumulate_macros.svh"

  localparam int Aw = $clog2(Dim * Dim);
  localparam int Iw = $clog2(Dim);
  localparam int Cw = $clog2(Dim + 1);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StIssue = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [Cw-1:0] n_q, n_d;
  logic [Iw-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic          s1_vld_q, s1_first_q, s1_last_q;
  logic          p_vld_q, p_last_q;
  word_t         prod_q, acc_q;
  logic          k_last, j_last, i_last, wb;

  assign k_last = (Cw'(k_q) + Cw'(1)) == n_q;
  assign j_last = (Cw'(j_q) + Cw'(1)) == n_q;
  assign i_last = (Cw'(i_q) + Cw'(1)) == n_q;
  assign wb     = p_vld_q && p_last_q;

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    unique case (state_q)
      StIdle: begin
        if (start_i && (size_i != '0)) begin
          n_d     = size_i;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
          state_d = StIssue;
        end
      end
      StIssue: begin
        k_d = k_q + Iw'(1);
        if (k_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (wb) begin
          k_d     = '0;
          state_d = StIssue;
          if (j_last) begin
            j_d = '0;
            if (i_last) begin
              state_d = StIdle;
            end else begin
              i_d = i_q + Iw'(1);
            end
          end else begin
            j_d = j_q + Iw'(1);
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      n_q        <= '0;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      s1_vld_q   <= 1'b0;
      s1_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
      p_vld_q    <= 1'b0;
      p_last_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      n_q        <= n_d;
      i_q        <= i_d;
      j_q        <= j_d;
      k_q        <= k_d;
      s1_vld_q   <= (state_q == StIssue);
      s1_first_q <= (state_q == StIssue) && (k_q == '0);
      s1_last_q  <= (state_q == StIssue) && k_last;
      p_vld_q    <= s1_vld_q;
      p_last_q   <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_rdata_i * b_rdata_i;
    if (s1_first_q) begin
      acc_q <= c_rdata_i;
    end else if (p_vld_q) begin
      acc_q <= acc_q + prod_q;
    end
  end

  assign a_raddr_o = Aw'(32'(i_q) * Dim + 32'(k_q));
  assign b_raddr_o = Aw'(32'(k_q) * Dim + 32'(j_q));
  assign c_raddr_o = Aw'(32'(i_q) * Dim + 32'(j_q));
  assign c_waddr_o = c_raddr_o;
  assign c_wdata_o = acc_q + prod_q;

  assign stat_o.busy  = (state_q != StIdle);
  assign stat_o.rd_en = (state_q == StIssue);
  assign stat_o.c_we  = wb;

  `MMA_NEVER(a_acc_collide, clk_i, rst_ni, s1_first_q && p_vld_q)
  `MMA_ASSERT(a_issue_feeds, clk_i, rst_ni, (state_q == StIssue) |=> s1_vld_q)
  `MMA_ASSERT(a_wb_in_drain, clk_i, rst_ni, wb |-> (state_q == StDrain))
  `MMA_ASSERT(a_start_idle, clk_i, rst_ni, start_i |-> (state_q == StIdle))

endmodule

`default_nettype wire

// File: rtl/matrix_multiply_accumulate.sv
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate
// Square unsigned 32-bit C += A*B over three element memories, with element
// loads, an accumulate request and element read-back of C.
// ----------------------------------------------------------------------------
//  Port       Dir  Handshake            Carries
//  req_i      in   valid/ready          mode, row, col, value
//  rsp_o      out  valid/ready          element, out_row, out_col
//  cfg_*_i    in   write enable only    size_in_use
//
// Loads can follow back to back while no read of C is in flight. A read of C
// passes through the memory read register and then the output register. An
// accumulate of size n (saturated to DIM) keeps the block busy while the
// single multiply-add unit works through the output elements, fed one A and
// one B element per cycle from the memories while it issues. Reset clears
// only the control state; the memories hold nothing until written. A stalled
// result blocks new requests only while it is held.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_accumulate #(
  parameter int Dim = mma_pkg::DimDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire mma_pkg::size_t  cfg_wdata_i,
  mma_in_if.sink               req_i,
  mma_out_if.source            rsp_o
);
  import mma_pkg::*;

`include "matrix_multiply_accumulate_macros.svh"

  localparam int Aw    = $clog2(Dim * Dim);
  localparam int Depth = Dim * Dim;
  localparam int Cw    = $clog2(Dim + 1);

  size_t         size_q;
  logic          in_accept, in_range;
  logic [Aw-1:0] item_addr;
  logic          a_we, b_we, c_item_we, rd_req, acc_req;
  logic [Cw-1:0] size_sat;

  logic          rd_pend_q, pend_inside_q;
  idx_t          pend_row_q, pend_col_q;
  logic          out_valid_q;
  word_t         element_q;
  idx_t          out_row_q, out_col_q;

  seq_stat_t     stat;
  logic [Aw-1:0] seq_a_raddr, seq_b_raddr, seq_c_raddr, seq_c_waddr;
  word_t         seq_c_wdata;
  word_t         a_rdata, b_rdata, c_rdata;

  logic          c_we, c_re;
  logic [Aw-1:0] c_waddr, c_raddr;
  word_t         c_wdata;

  assign req_i.ready = !stat.busy && !rd_pend_q && !(out_valid_q && !rsp_o.ready);
  assign in_accept   = req_i.valid && req_i.ready;
  assign in_range    = (int'(req_i.row) < Dim) && (int'(req_i.col) < Dim);
  assign item_addr   = Aw'(32'(req_i.row) * Dim + 32'(req_i.col));
  assign size_sat    = (int'(size_q) > Dim) ? Cw'(Dim) : Cw'(size_q);

  always_comb begin
    a_we      = 1'b0;
    b_we      = 1'b0;
    c_item_we = 1'b0;
    rd_req    = 1'b0;
    acc_req   = 1'b0;
    unique case (req_i.mode)
      ModeWrA: a_we      = in_accept && in_range;
      ModeWrB: b_we      = in_accept && in_range;
      ModeWrC: c_item_we = in_accept && in_range;
      ModeAcc: acc_req   = in_accept;
      ModeRdC: rd_req    = in_accept;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= size_t'(SizeReset);
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  mma_seq #(
    .Dim (Dim)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (acc_req),
    .size_i    (size_sat),
    .a_rdata_i (a_rdata),
    .b_rdata_i (b_rdata),
    .c_rdata_i (c_rdata),
    .a_raddr_o (seq_a_raddr),
    .b_raddr_o (seq_b_raddr),
    .c_raddr_o (seq_c_raddr),
    .c_waddr_o (seq_c_waddr),
    .c_wdata_o (seq_c_wdata),
    .stat_o    (stat)
  );

  assign c_we    = c_item_we || stat.c_we;
  assign c_waddr = stat.c_we ? seq_c_waddr : item_addr;
  assign c_wdata = stat.c_we ? seq_c_wdata : req_i.value;
  assign c_re    = rd_req || stat.rd_en;
  assign c_raddr = stat.rd_en ? seq_c_raddr : item_addr;

  mma_ram #(
    .Width (32),
    .Depth (Depth)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (item_addr),
    .wdata_i (req_i.value),
    .re_i    (stat.rd_en),
    .raddr_i (seq_a_raddr),
    .rdata_o (a_rdata)
  );

  mma_ram #(
    .Width (32),
    .Depth (Depth)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (item_addr),
    .wdata_i (req_i.value),
    .re_i    (stat.rd_en),
    .raddr_i (seq_b_raddr),
    .rdata_o (b_rdata)
  );

  mma_ram #(
    .Width (32),
    .Depth (Depth)
  ) u_ram_c (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .re_i    (c_re),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= rd_req;
      if (rd_pend_q) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_req) begin
      pend_inside_q <= in_range;
      pend_row_q    <= req_i.row;
      pend_col_q    <= req_i.col;
    end
    if (rd_pend_q) begin
      element_q <= pend_inside_q ? c_rdata : '0;
      out_row_q <= pend_row_q;
      out_col_q <= pend_col_q;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.element = element_q;
  assign rsp_o.out_row = out_row_q;
  assign rsp_o.out_col = out_col_q;

  `MMA_ASSERT(a_pend_fills, clk_i, rst_ni, rd_pend_q |=> out_valid_q)
  `MMA_ASSERT(a_pend_empty, clk_i, rst_ni, rd_pend_q |-> !out_valid_q)
  `MMA_ASSERT(a_no_accept_busy, clk_i, rst_ni, in_accept |-> !stat.busy)

endmodule

`default_nettype wire

// File: tb/mma_result_checker.sv
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate result checker
// Watches the request, response and configuration ports of the block, keeps
// its own copy of A, B, C and the size register, and compares every returned
// element of C with the oldest predicted read.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mma_result_checker #(
  parameter int Dim = mma_pkg::DimDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire mma_pkg::size_t cfg_wdata_i,
  mma_in_if                   req,
  mma_out_if                  rsp,
  output int                  fail_count_o,
  output int                  pending_o
);
  import mma_pkg::*;

  typedef struct packed {
    word_t element;
    idx_t  row;
    idx_t  col;
  } c_read_t;

  word_t   mat_a [Dim*Dim];
  word_t   mat_b [Dim*Dim];
  word_t   mat_c [Dim*Dim];
  size_t   size_q;
  c_read_t pending_reads [$];
  int      fails;

  function automatic void accumulate_c();
    int    n;
    word_t acc;
    n = (size_q > Dim) ? Dim : int'(size_q);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = mat_c[i*Dim + j];
        for (int k = 0; k < n; k++) begin
          acc = acc + mat_a[i*Dim + k] * mat_b[k*Dim + j];
        end
        mat_c[i*Dim + j] = acc;
      end
    end
  endfunction

  function automatic void apply_request(mode_t mode, idx_t row, idx_t col, word_t value);
    bit in_range;
    int addr;
    in_range = (row < Dim) && (col < Dim);
    addr     = in_range ? row * Dim + col : 0;
    case (mode)
      ModeWrA: if (in_range) mat_a[addr] = value;
      ModeWrB: if (in_range) mat_b[addr] = value;
      ModeWrC: if (in_range) mat_c[addr] = value;
      ModeAcc: accumulate_c();
      ModeRdC: pending_reads.push_back('{element: in_range ? mat_c[addr] : '0,
                                         row: row, col: col});
      default: ;
    endcase
  endfunction

  function automatic void check_element();
    c_read_t exp;
    if (pending_reads.size() == 0) begin
      $error("element %h at (%0d, %0d) returned with no read pending",
             rsp.element, rsp.out_row, rsp.out_col);
      fails++;
      return;
    end
    exp = pending_reads.pop_front();
    if (rsp.element !== exp.element) begin
      $error("element: expected %h, got %h", exp.element, rsp.element);
      fails++;
    end
    if (rsp.out_row !== exp.row) begin
      $error("out_row: expected %0d, got %0d", exp.row, rsp.out_row);
      fails++;
    end
    if (rsp.out_col !== exp.col) begin
      $error("out_col: expected %0d, got %0d", exp.col, rsp.out_col);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q = size_t'(SizeReset);
      pending_reads.delete();
    end else begin
      if (cfg_we_i) size_q = cfg_wdata_i;
      if (rsp.valid && rsp.ready) check_element();
      if (req.valid && req.ready) apply_request(req.mode, req.row, req.col, req.value);
    end
    pending_o    <= pending_reads.size();
    fail_count_o <= fails;
  end

  initial begin
    fails        = 0;
    fail_count_o = 0;
    pending_o    = 0;
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate testbench
// Loads elements of A, B and C, runs accumulates over several matrix sizes
// and reads C back, with random gaps on both channels and one long response
// stall. Only entries already written are ever used, and the size register
// changes only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import mma_pkg::*;

  localparam int    Dim          = DimDefault;
  localparam int    AccCyclesMax = Dim * Dim * (Dim + 2);
  localparam int    ItemTarget   = 750;
  localparam int    HoldCycles   = 200;
  localparam int    DrainLimit   = 20000;
  localparam mode_t ModeSpareLo  = 3'd5;
  localparam mode_t ModeSpareHi  = 3'd7;

  logic  clk_i;
  logic  rst_ni;
  logic  cfg_we_i;
  size_t cfg_wdata_i;

  mma_in_if  req_if ();
  mma_out_if rsp_if ();

  int             fail_count;
  int             pending;
  bit             quiet;
  bit             hold_req;
  bit [Dim*Dim-1:0] a_set;
  bit [Dim*Dim-1:0] b_set;
  bit [Dim*Dim-1:0] c_set;
  int             size_now;
  int             item_count;

  matrix_multiply_accumulate #(.Dim(Dim)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  mma_result_checker #(.Dim(Dim)) result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req          (req_if),
    .rsp          (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("matrix_multiply_accumulate: mismatch");
    $finish;
  end

  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return word_t'(1);
      default: return word_t'($urandom());
    endcase
  endfunction

  function automatic idx_t pick_index(int n);
    if (n > 0 && $urandom_range(0, 3) != 0) return idx_t'($urandom_range(0, n - 1));
    return idx_t'($urandom_range(0, Dim - 1));
  endfunction

  function automatic int pick_written_c();
    int idx;
    for (int t = 0; t < 64; t++) begin
      idx = $urandom_range(0, Dim * Dim - 1);
      if (c_set[idx]) return idx;
    end
    return 0;
  endfunction

  function automatic int used_size();
    return (size_now > Dim) ? Dim : size_now;
  endfunction

  function automatic bit acc_legal();
    int n;
    n = used_size();
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        if (!(a_set[i*Dim + j] && b_set[i*Dim + j] && c_set[i*Dim + j])) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic send_req(mode_t mode, idx_t row, idx_t col, word_t value);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.mode  <= mode;
    req_if.row   <= row;
    req_if.col   <= col;
    req_if.value <= value;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    item_count++;
    case (mode)
      ModeWrA: a_set[row*Dim + col] = 1'b1;
      ModeWrB: b_set[row*Dim + col] = 1'b1;
      ModeWrC: c_set[row*Dim + col] = 1'b1;
      default: ;
    endcase
  endtask

  task automatic read_c(int idx);
    send_req(ModeRdC, idx_t'(idx / Dim), idx_t'(idx % Dim), word_t'($urandom()));
  endtask

  task automatic set_size(int s);
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (AccCyclesMax + 8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size_t'(s);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    size_now = s;
  endtask

  task automatic load_block(int n);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        if (!a_set[i*Dim + j]) send_req(ModeWrA, idx_t'(i), idx_t'(j), rand_word());
        if (!b_set[i*Dim + j]) send_req(ModeWrB, idx_t'(i), idx_t'(j), rand_word());
        if (!c_set[i*Dim + j]) send_req(ModeWrC, idx_t'(i), idx_t'(j), rand_word());
      end
    end
  endtask

  task automatic run_phase(int s, int phase);
    int    r;
    int    n;
    mode_t m;
    set_size(s);
    quiet = ($urandom_range(0, 3) == 0);
    n = used_size();
    load_block(n);
    if (phase == 2) begin
      hold_req = 1'b1;
      repeat (12) read_c(pick_written_c());
    end
    repeat ($urandom_range(10, 30)) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        m = mode_t'($urandom_range(ModeWrA, ModeWrC));
        send_req(m, pick_index(n), pick_index(n), rand_word());
      end else if (r < 55 && acc_legal()) begin
        send_req(ModeAcc, idx_t'($urandom()), idx_t'($urandom()), word_t'($urandom()));
      end else if (r < 92) begin
        read_c(pick_written_c());
      end else begin
        m = mode_t'($urandom_range(ModeSpareLo, ModeSpareHi));
        send_req(m, idx_t'($urandom()), idx_t'($urandom()), word_t'($urandom()));
      end
    end
    read_c(pick_written_c());
  endtask

  // Response side: random stalls, plus one long hold-off when requested.
  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        rsp_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      stall = quiet ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
    end
  end

  initial begin
    int s;
    int r;
    int phase;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    req_if.valid <= 1'b0;
    req_if.mode  <= ModeWrA;
    req_if.row   <= '0;
    req_if.col   <= '0;
    req_if.value <= '0;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    a_set      = '0;
    b_set      = '0;
    c_set      = '0;
    size_now   = SizeReset;
    item_count = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: full-scale wrap, corners, spare modes and size zero.
    set_size(1);
    send_req(ModeWrA, 3'd0, 3'd0, '1);
    send_req(ModeWrB, 3'd0, 3'd0, '1);
    send_req(ModeWrC, 3'd0, 3'd0, '0);
    send_req(ModeAcc, 3'd0, 3'd0, '0);
    read_c(0);
    send_req(ModeWrC, 3'd7, 3'd7, '1);
    read_c(Dim * Dim - 1);
    send_req(ModeWrA, 3'd7, 3'd0, 32'h8000_0000);
    send_req(ModeWrB, 3'd0, 3'd7, 32'h0000_0001);
    for (int m = ModeSpareLo; m <= ModeSpareHi; m++) begin
      send_req(mode_t'(m), 3'd7, 3'd7, '1);
    end
    read_c(0);
    send_req(ModeWrC, 3'd0, 3'd0, 32'h8000_0000);
    read_c(0);
    set_size(0);
    send_req(ModeAcc, 3'd7, 3'd7, '1);
    read_c(0);

    // Random part: sized phases of loads, accumulates and read-back.
    phase = 0;
    while (item_count < ItemTarget) begin
      case (phase)
        0: s = 2;
        1: s = 15;
        2: s = 8;
        3: s = 0;
        default: begin
          r = $urandom_range(0, 99);
          if (r < 60)      s = $urandom_range(1, 4);
          else if (r < 80) s = $urandom_range(5, Dim);
          else if (r < 90) s = 0;
          else             s = $urandom_range(Dim + 1, 15);
        end
      endcase
      run_phase(s, phase);
      phase++;
    end

    req_if.valid <= 1'b0;
    @(posedge clk_i);
    for (int w = 0; w < DrainLimit && pending != 0; w++) @(posedge clk_i);
    repeat (AccCyclesMax + 8) @(posedge clk_i);
    if (pending != 0) $error("%0d read results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("matrix_multiply_accumulate: match");
    end else begin
      $display("matrix_multiply_accumulate: mismatch");
    end
    $finish;
  end

endmodule
